// ===== src/irlpe_pkg.sv =====
package irlpe_pkg;

    localparam int SENSOR_COUNT_DEF = 8;
    localparam int CAL_ROUNDS_DEF   = 10;
    localparam int ADC_BITS_DEF     = 10;

    localparam int CMD_W  = 2;
    localparam int SMP_W  = 10;
    localparam int STS_W  = 2;
    localparam int POS_W  = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;
    localparam int ACC_W  = 16;
    localparam int AVG_W  = 10;
    localparam int NRM_W  = 10;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CAL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

    localparam logic [STS_W-1:0] STS_POS    = 2'd0;
    localparam logic [STS_W-1:0] STS_CALDN  = 2'd1;
    localparam logic [STS_W-1:0] STS_NOCAL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SPS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NTH   = 3'd4;

    localparam logic [POS_W-1:0] POS_SAT = 13'd8191;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SMP_W-1:0] adc_sample;
    } t_in_item;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [POS_W-1:0] position;
        logic             line_seen;
    } t_out_item;

    typedef struct packed {
        logic             is_cal;
        logic             is_clear;
        logic [SMP_W-1:0] sample;
    } t_op;

endpackage

// ===== src/irlpe_stream_if.sv =====
interface irlpe_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/irlpe_front.sv =====
module irlpe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cal_en,
    irlpe_stream_if.sink      s_in,
    output logic              o_valid,
    output irlpe_pkg::t_op    o_op,
    input  logic              i_ready
);
    logic            r_valid;
    irlpe_pkg::t_op  r_op;
    logic            w_take;
    logic            w_keep;

    assign s_in.ready = !r_valid || i_ready;
    assign w_take = s_in.valid && s_in.ready;
    assign w_keep = (s_in.data.cmd == irlpe_pkg::CMD_READ)
                 || (s_in.data.cmd == irlpe_pkg::CMD_CLEAR)
                 || (s_in.data.cmd == irlpe_pkg::CMD_CAL && i_cal_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= w_keep;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (w_take) begin
            r_op.is_cal   <= (s_in.data.cmd == irlpe_pkg::CMD_CAL);
            r_op.is_clear <= (s_in.data.cmd == irlpe_pkg::CMD_CLEAR);
            r_op.sample   <= s_in.data.adc_sample;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
endmodule

// ===== src/irlpe_divider.sv =====
module irlpe_divider #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_done;
    logic [DEN_W:0]   w_sh;
    logic [DEN_W:0]   w_sub;

    assign w_sh  = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_sub[DEN_W]) begin
                r_rem <= w_sub;
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

// ===== src/irlpe_back.sv =====
module irlpe_back #(
    parameter int SENSOR_COUNT = irlpe_pkg::SENSOR_COUNT_DEF,
    parameter int CAL_ROUNDS   = irlpe_pkg::CAL_ROUNDS_DEF,
    parameter int ADC_BITS     = irlpe_pkg::ADC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  irlpe_pkg::t_op        i_op,
    output logic                  o_ready,
    input  logic [6:0]            i_sps,
    input  logic [9:0]            i_amax,
    input  logic [9:0]            i_lth,
    input  logic [9:0]            i_nth,
    irlpe_stream_if.source        m_out
);
    localparam int CH_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int RND_W = $clog2(CAL_ROUNDS + 1);
    localparam int WSUM_W = 32;
    localparam int TOT_W  = 16;
    localparam int DIV_W  = 32;
    localparam int SMP_W  = irlpe_pkg::SMP_W;
    localparam logic [SMP_W-1:0] ADC_MASK = SMP_W'((1 << ADC_BITS) - 1);
    localparam logic [31:0] EDGE_POS = 32'((SENSOR_COUNT - 1) * 1000);
    localparam logic [31:0] HALF_POS = 32'((SENSOR_COUNT - 1) * 1000 / 2);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AVG   = 4'd1;
    localparam logic [3:0] S_AVGW  = 4'd2;
    localparam logic [3:0] S_CAL   = 4'd3;
    localparam logic [3:0] S_NRM   = 4'd4;
    localparam logic [3:0] S_NRMW  = 4'd5;
    localparam logic [3:0] S_NACC  = 4'd6;
    localparam logic [3:0] S_POS   = 4'd7;
    localparam logic [3:0] S_POSW  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_CALE  = 4'd10;

    logic [3:0]  r_st;
    logic [15:0] r_acc   [SENSOR_COUNT];
    logic [9:0]  r_avg   [SENSOR_COUNT];
    logic [9:0]  r_smax  [SENSOR_COUNT];
    logic [9:0]  r_smin  [SENSOR_COUNT];
    logic [9:0]  r_cmax  [SENSOR_COUNT];
    logic [9:0]  r_cmin  [SENSOR_COUNT];
    logic [CH_W-1:0]  r_ch;
    logic [5:0]       r_smp;
    logic [RND_W-1:0] r_rnd;
    logic             r_calf;
    logic [12:0]      r_prev;
    logic             r_is_cal;
    logic [CH_W-1:0]  r_idx;
    logic [9:0]       r_nv;
    logic             r_seen;
    logic [WSUM_W-1:0] r_wsum;
    logic [TOT_W-1:0]  r_tot;
    logic              r_ovalid;
    irlpe_pkg::t_out_item r_out;

    logic [6:0]  w_n;
    logic        w_start;
    logic [DIV_W-1:0] w_num;
    logic [15:0] w_den;
    logic        w_done;
    logic [DIV_W-1:0] w_quo;
    logic [10:0] w_sd;
    logic [15:0] w_span;
    logic [25:0] w_prod;
    logic [12:0] w_posq;
    logic        w_last_ch;
    logic [SMP_W-1:0] w_smp;

    always_comb begin
        w_n = i_sps;
        if (w_n == 7'd0) w_n = 7'd1;
        if (w_n > 7'd64) w_n = 7'd64;
    end

    assign w_smp     = i_op.sample & ADC_MASK;
    assign w_last_ch = (r_ch == CH_W'(SENSOR_COUNT - 1));
    assign o_ready   = (r_st == S_IDLE);
    assign w_span    = 16'({6'd0, r_cmax[r_idx]} - {6'd0, r_cmin[r_idx]});
    assign w_sd      = {1'b0, r_avg[r_idx]} - {1'b0, r_cmin[r_idx]};
    assign w_prod    = 26'(w_sd[9:0]) * 26'd1000;

    always_comb begin
        w_start = 1'b0;
        w_num   = '0;
        w_den   = 16'd1;
        case (r_st)
            S_AVG: begin
                w_start = 1'b1;
                w_num   = DIV_W'(r_acc[r_idx]) + DIV_W'(w_n >> 1);
                w_den   = 16'(w_n);
            end
            S_NRM: begin
                w_start = !w_sd[10] && (w_span != 16'd0);
                w_num   = DIV_W'(w_prod);
                w_den   = w_span;
            end
            S_POS: begin
                w_start = 1'b1;
                w_num   = r_wsum;
                w_den   = r_tot;
            end
            default: begin
            end
        endcase
    end

    irlpe_divider #(.NUM_W(DIV_W), .DEN_W(16)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    assign w_posq = (w_quo > DIV_W'(irlpe_pkg::POS_SAT)) ? irlpe_pkg::POS_SAT
                                                         : w_quo[12:0];
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ch     <= '0;
            r_smp    <= '0;
            r_rnd    <= '0;
            r_calf   <= 1'b0;
            r_prev   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                r_acc[i]  <= '0;
                r_cmax[i] <= '0;
                r_cmin[i] <= '1;
            end
        end else begin
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_op.is_clear) begin
                            for (int i = 0; i < SENSOR_COUNT; i++) begin
                                r_cmax[i] <= '0;
                                r_cmin[i] <= i_amax;
                            end
                        end else begin
                            r_acc[r_ch] <= r_acc[r_ch] + 16'(w_smp);
                            r_ch <= w_last_ch ? '0 : r_ch + 1'b1;
                            if (w_last_ch) begin
                                if (7'(r_smp) + 7'd1 >= w_n) begin
                                    r_smp    <= '0;
                                    r_is_cal <= i_op.is_cal;
                                    r_idx    <= '0;
                                    r_st     <= S_AVG;
                                end else begin
                                    r_smp <= r_smp + 1'b1;
                                end
                            end
                        end
                    end
                end
                S_AVG: r_st <= S_AVGW;
                S_AVGW: begin
                    if (w_done) begin
                        r_avg[r_idx] <= w_quo[9:0];
                        r_acc[r_idx] <= '0;
                        if (r_idx == CH_W'(SENSOR_COUNT - 1)) begin
                            r_idx <= '0;
                            r_seen <= 1'b0;
                            r_wsum <= '0;
                            r_tot  <= '0;
                            if (r_is_cal) r_st <= S_CAL;
                            else if (!r_calf) begin
                                if (!r_ovalid || m_out.ready) begin
                                    r_out.status    <= irlpe_pkg::STS_NOCAL;
                                    r_out.position  <= '0;
                                    r_out.line_seen <= 1'b0;
                                    r_ovalid <= 1'b1;
                                    r_st <= S_IDLE;
                                end else begin
                                    r_st <= S_OUT;
                                end
                            end else r_st <= S_NRM;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_st  <= S_AVG;
                        end
                    end
                end
                S_CAL: begin
                    if (r_rnd == '0 && !r_calf) begin
                        r_calf <= 1'b1;
                        for (int i = 0; i < SENSOR_COUNT; i++) begin
                            r_cmax[i] <= '0;
                            r_cmin[i] <= i_amax;
                        end
                    end
                    for (int i = 0; i < SENSOR_COUNT; i++) begin
                        if (r_rnd == '0 || r_avg[i] > r_smax[i]) r_smax[i] <= r_avg[i];
                        if (r_rnd == '0 || r_avg[i] < r_smin[i]) r_smin[i] <= r_avg[i];
                    end
                    if (r_rnd + 1'b1 >= RND_W'(CAL_ROUNDS)) begin
                        r_rnd <= '0;
                        r_st  <= S_CALE;
                    end else begin
                        r_rnd <= r_rnd + 1'b1;
                        r_st  <= S_IDLE;
                    end
                end
                S_CALE: begin
                    if (!r_ovalid || m_out.ready) begin
                        for (int i = 0; i < SENSOR_COUNT; i++) begin
                            if (r_smin[i] > r_cmax[i]) r_cmax[i] <= r_smin[i];
                            if (r_smax[i] < r_cmin[i]) r_cmin[i] <= r_smax[i];
                        end
                        r_out.status    <= irlpe_pkg::STS_CALDN;
                        r_out.position  <= '0;
                        r_out.line_seen <= 1'b0;
                        r_ovalid <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                S_NRM: begin
                    if (w_start) r_st <= S_NRMW;
                    else begin
                        r_nv <= '0;
                        r_st <= S_NACC;
                    end
                end
                S_NRMW: begin
                    if (w_done) begin
                        r_nv <= (w_quo > DIV_W'(1000)) ? 10'd1000 : w_quo[9:0];
                        r_st <= S_NACC;
                    end
                end
                S_NACC: begin
                    if (r_nv > i_lth) r_seen <= 1'b1;
                    if (r_nv > i_nth) begin
                        r_wsum <= r_wsum + WSUM_W'(r_nv) * WSUM_W'(32'(r_idx) * 1000);
                        r_tot  <= r_tot + TOT_W'(r_nv);
                    end
                    if (r_idx == CH_W'(SENSOR_COUNT - 1)) r_st <= S_POS;
                    else begin
                        r_idx <= r_idx + 1'b1;
                        r_st  <= S_NRM;
                    end
                end
                S_POS: begin
                    if (r_seen && r_tot != '0) r_st <= S_POSW;
                    else r_st <= S_OUT;
                end
                S_POSW: begin
                    if (w_done) begin
                        r_prev <= w_posq;
                        r_st   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || m_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_st <= S_IDLE;
                        if (!r_calf) begin
                            r_out.status    <= irlpe_pkg::STS_NOCAL;
                            r_out.position  <= '0;
                            r_out.line_seen <= 1'b0;
                        end else begin
                            r_out.status    <= irlpe_pkg::STS_POS;
                            r_out.line_seen <= r_seen;
                            if (r_seen) r_out.position <= r_prev;
                            else if (32'(r_prev) < HALF_POS) r_out.position <= '0;
                            else if (EDGE_POS > 32'(irlpe_pkg::POS_SAT))
                                r_out.position <= irlpe_pkg::POS_SAT;
                            else r_out.position <= EDGE_POS[12:0];
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/ir_line_position_estimator_top.sv =====
// Line position estimator for a row of reflectance sensors.
// Input channel s_in carries {cmd, adc_sample}, conversions channel-inner,
// sample-outer. Output channel m_out carries {status, position, line_seen},
// one item at the end of each read frame or calibration run.
// Configuration: write enable, register index and data, written while idle.
// Throughput: one conversion per cycle while a frame fills. The last
// conversion of a frame starts frame processing in the back end, which runs
// all work on one shared 32-step restoring divider: each channel average,
// then each normalized channel, then the position, then the output register.
// A one-entry queue between front and back end absorbs a single item during
// frame processing. Reset (synchronous, active low) clears accumulators,
// counters, calibration window and registers to their defaults. When the
// receiver stalls, the result waits in the output register and the back end
// holds.
module ir_line_position_estimator_top #(
    parameter int SENSOR_COUNT = irlpe_pkg::SENSOR_COUNT_DEF,
    parameter int CAL_ROUNDS   = irlpe_pkg::CAL_ROUNDS_DEF,
    parameter int ADC_BITS     = irlpe_pkg::ADC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [irlpe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [irlpe_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    irlpe_stream_if.sink                       s_in,
    irlpe_stream_if.source                     m_out
);
    logic [6:0] r_sps;
    logic       r_calen;
    logic [9:0] r_amax;
    logic [9:0] r_lth;
    logic [9:0] r_nth;
    logic           w_fv;
    logic           w_br;
    irlpe_pkg::t_op w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps   <= 7'd4;
            r_calen <= 1'b1;
            r_amax  <= 10'd1023;
            r_lth   <= 10'd200;
            r_nth   <= 10'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                irlpe_pkg::REG_SPS:   r_sps   <= i_cfg_data[6:0];
                irlpe_pkg::REG_CALEN: r_calen <= i_cfg_data[0];
                irlpe_pkg::REG_AMAX:  r_amax  <= i_cfg_data;
                irlpe_pkg::REG_LTH:   r_lth   <= i_cfg_data;
                irlpe_pkg::REG_NTH:   r_nth   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    irlpe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cal_en (r_calen),
        .s_in     (s_in),
        .o_valid  (w_fv),
        .o_op     (w_op),
        .i_ready  (w_br)
    );

    irlpe_back #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .CAL_ROUNDS   (CAL_ROUNDS),
        .ADC_BITS     (ADC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .i_op    (w_op),
        .o_ready (w_br),
        .i_sps   (r_sps),
        .i_amax  (r_amax),
        .i_lth   (r_lth),
        .i_nth   (r_nth),
        .m_out   (m_out)
    );
endmodule
